[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, off while arst_n is low.
`define U8D_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check an implication: when cond holds, concl holds in the same cycle.
`define U8D_ASSERT_IMPL(label, cond, concl, msg) \
	`U8D_ASSERT(label, (cond) |-> (concl), msg)

`endif

[hw/rtl/u8d_pkg.sv]
package u8d_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned CodeW  = 21;
	localparam int unsigned StatW  = 2;
	localparam int unsigned CountW = 3;

	// Result status codes
	localparam logic [StatW-1:0] ST_OK      = 2'd0;
	localparam logic [StatW-1:0] ST_LONE    = 2'd1;
	localparam logic [StatW-1:0] ST_TRUNC   = 2'd2;
	localparam logic [StatW-1:0] ST_INVALID = 2'd3;

	// Decoder state carried between bytes
	typedef struct packed {
		logic [1:0]        bytes_left;
		logic [CountW-1:0] seq_length;
		logic [CodeW-1:0]  code_accum;
		logic              broken_flag;
	} state_t;

	// One decoded character, with a flag saying whether the byte produced one
	typedef struct packed {
		logic              emit;
		logic [CodeW-1:0]  code_point;
		logic [StatW-1:0]  status;
		logic [CountW-1:0] byte_count;
	} result_t;

endpackage

[hw/rtl/u8d_byte_if.sv]
interface u8d_byte_if;
	logic                      valid;
	logic                      ready;
	logic [u8d_pkg::ByteW-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

[hw/rtl/u8d_char_if.sv]
interface u8d_char_if;
	logic                       valid;
	logic                       ready;
	logic [u8d_pkg::CodeW-1:0]  code_point;
	logic [u8d_pkg::StatW-1:0]  status;
	logic [u8d_pkg::CountW-1:0] byte_count;

	modport source (output valid, output code_point, output status, output byte_count,
		input ready);
	modport sink   (input valid, input code_point, input status, input byte_count,
		output ready);
endinterface

[hw/rtl/utf8_byte_stream_decoder.sv]
// Channel   | Dir | Payload                            | Transaction
// byte_chan | in  | in_byte[7:0]                       | one raw text byte
// char_chan | out | code_point[20:0] status[1:0]       | one decoded character
//           |     | byte_count[2:0]                    |
//
// One byte per cycle sustained while char_chan is ready; a character leaves
// after its last byte is taken, via the input and then the result register.
// The decode step is short mask/shift logic between byte_s1 and the result
// register, with the sequence state updated in the same cycle.
// arst_n clears the state, input and result valid flags; no warm-up needed.
// A stalled char_chan holds the byte in byte_s1 and then drops byte_chan.ready.
`include "assert_macros.svh"

module utf8_byte_stream_decoder (
	input  logic                clk,
	input  logic                arst_n,
	u8d_byte_if.sink            byte_chan,
	u8d_char_if.source          char_chan
);

	logic                            valid_s1;
	logic [u8d_pkg::ByteW-1:0]       byte_s1;
	u8d_pkg::state_t                 state_q;
	u8d_pkg::state_t                 state_next;
	u8d_pkg::result_t                result;
	logic                            out_valid_q;
	logic [u8d_pkg::CodeW-1:0]       code_point_q;
	logic [u8d_pkg::StatW-1:0]       status_q;
	logic [u8d_pkg::CountW-1:0]      byte_count_q;
	logic                            advance;

	// The input stage moves on when the result register is free or being drained
	assign advance         = valid_s1 && (!out_valid_q || char_chan.ready);
	assign byte_chan.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_chan.ready) begin
			valid_s1 <= byte_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_chan.ready && byte_chan.valid) begin
			byte_s1 <= byte_chan.in_byte;
		end
	end

	u8d_step u_step (
		.in_byte    (byte_s1),
		.state      (state_q),
		.state_next (state_next),
		.result     (result)
	);

	// Sequence state advances only when the byte in stage 1 is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register: load on a completed character, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= result.emit;
		end else if (char_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.emit) begin
			code_point_q <= result.code_point;
			status_q     <= result.status;
			byte_count_q <= result.byte_count;
		end
	end

	assign char_chan.valid      = out_valid_q;
	assign char_chan.code_point = code_point_q;
	assign char_chan.status     = status_q;
	assign char_chan.byte_count = byte_count_q;

	// An open sequence always has more bytes in total than still due
	`U8D_ASSERT_IMPL(a_len_covers_left, state_q.bytes_left != 2'd0, state_q.seq_length > {1'b0, state_q.bytes_left}, "sequence length below bytes left")
	// Idle state is fully cleared
	`U8D_ASSERT_IMPL(a_idle_clear, state_q.bytes_left == 2'd0, state_q.seq_length == 3'd0 && state_q.code_accum == '0 && !state_q.broken_flag, "idle state not cleared")
	// Error results carry no code point
	`U8D_ASSERT_IMPL(a_err_zero, out_valid_q && (status_q == u8d_pkg::ST_INVALID || status_q == u8d_pkg::ST_TRUNC), code_point_q == '0, "error result with nonzero code point")
	// A truncated sequence always spans several bytes
	`U8D_ASSERT_IMPL(a_trunc_len, out_valid_q && status_q == u8d_pkg::ST_TRUNC, byte_count_q >= 3'd2 && byte_count_q <= 3'd4, "truncated result with bad byte count")
	// A byte waiting behind a full, stalled result register keeps its place
	`U8D_ASSERT(a_stall_hold, valid_s1 && out_valid_q && !char_chan.ready |=> valid_s1 && $stable(byte_s1) && $stable(state_q), "stage 1 moved during output stall")

endmodule

[hw/rtl/u8d_step.sv]
module u8d_step (
	input  logic [u8d_pkg::ByteW-1:0] in_byte,
	input  u8d_pkg::state_t           state,
	output u8d_pkg::state_t           state_next,
	output u8d_pkg::result_t          result
);

	logic                          is_cont;
	logic [1:0]                    left_dec;
	logic [u8d_pkg::CodeW-1:0]     cont_bits;
	u8d_pkg::state_t               mid;

	assign is_cont  = (in_byte[7:6] == 2'b10);
	assign left_dec = state.bytes_left - 2'd1;

	// Place six payload bits by the number of continuation bytes still due
	always_comb begin
		case (state.bytes_left)
			2'd1:    cont_bits = {15'd0, in_byte[5:0]};
			2'd2:    cont_bits = {9'd0, in_byte[5:0], 6'd0};
			2'd3:    cont_bits = {3'd0, in_byte[5:0], 12'd0};
			default: cont_bits = '0;
		endcase
	end

	always_comb begin
		state_next = state;
		result     = '0;
		mid        = state;
		if (state.bytes_left == 2'd0) begin
			unique case (in_byte) inside
				8'b0???_????: begin
					result = '{1'b1, {13'd0, in_byte}, u8d_pkg::ST_OK, 3'd1};
				end
				8'b10??_????: begin
					result = '{1'b1, {13'd0, in_byte}, u8d_pkg::ST_LONE, 3'd1};
				end
				8'b110?_????: begin
					state_next = '{2'd1, 3'd2, {10'd0, in_byte[4:0], 6'd0}, 1'b0};
				end
				8'b1110_????: begin
					state_next = '{2'd2, 3'd3, {5'd0, in_byte[3:0], 12'd0}, 1'b0};
				end
				8'b1111_0???: begin
					state_next = '{2'd3, 3'd4, {in_byte[2:0], 18'd0}, 1'b0};
				end
				default: begin
					result = '{1'b1, '0, u8d_pkg::ST_INVALID, 3'd1};
				end
			endcase
		end else begin
			// Accumulate a good continuation, otherwise mark the sequence broken
			if (!state.broken_flag && is_cont) begin
				mid.code_accum = state.code_accum | cont_bits;
			end else begin
				mid.broken_flag = 1'b1;
			end
			mid.bytes_left = left_dec;
			if (left_dec == 2'd0) begin
				result.emit       = 1'b1;
				result.code_point = mid.broken_flag ? '0 : mid.code_accum;
				result.status     = mid.broken_flag ? u8d_pkg::ST_TRUNC : u8d_pkg::ST_OK;
				result.byte_count = state.seq_length;
				state_next        = '0;
			end else begin
				state_next = mid;
			end
		end
	end

endmodule

[tb/sv/utf8_byte_stream_decoder_tb.sv]
module utf8_byte_stream_decoder_tb;

	// Cycles with no transaction on either channel before the run is declared hung.
	localparam int unsigned IdleLimit   = 1000;
	// Length of the one long output stall in the full-rate phase.
	localparam int unsigned HoldCycles  = 80;
	// Settle time after the last character: input register plus result register, with margin.
	localparam int unsigned DrainCycles = 8;
	// Keep a badly broken design from flooding the log.
	localparam int unsigned MaxPrints   = 40;

	typedef struct packed {
		logic [u8d_pkg::CodeW-1:0]  code_point;
		logic [u8d_pkg::StatW-1:0]  status;
		logic [u8d_pkg::CountW-1:0] byte_count;
	} char_t;

	// Idle profiles, in run order.
	typedef enum logic [1:0] {
		PH_SEND_FAST,  // sender idles rarely, receiver often
		PH_RECV_FAST,  // the other way round
		PH_FULL_RATE   // no random idling; one long output hold
	} phase_e;

	logic clk = 1'b0;
	logic arst_n;

	u8d_byte_if byte_chan ();
	u8d_char_if char_chan ();

	utf8_byte_stream_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_chan (byte_chan),
		.char_chan (char_chan)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stimulus and idling controls, set by the sequencing block; the byte driver also pops bytes_pending.
	logic [7:0]  bytes_pending [$];
	phase_e      phase;
	int unsigned send_gap_pct;
	int unsigned recv_gap_pct;
	int unsigned hold_mark;

	// Decoder state as predicted from the bytes that have been taken.
	logic [1:0]                 cont_left;
	logic [u8d_pkg::CountW-1:0] seq_len;
	logic [u8d_pkg::CodeW-1:0]  cp_accum;
	logic                       seq_broken;
	char_t                      chars_due [$];

	// Bookkeeping.
	logic        byte_took;
	int unsigned bytes_taken;
	int unsigned chars_checked;
	int unsigned status_seen [4];
	int unsigned fails;
	int unsigned idle_cycles;
	int unsigned hold_left;
	logic        hold_used;

	function automatic char_t make_char(input logic [u8d_pkg::CodeW-1:0] cp,
			input logic [u8d_pkg::StatW-1:0] st, input logic [u8d_pkg::CountW-1:0] cnt);
		char_t c;
		c.code_point = cp;
		c.status     = st;
		c.byte_count = cnt;
		return c;
	endfunction

	// Advance the predicted decoder by one byte; queue the character it completes, if any.
	task automatic decode_byte(input logic [u8d_pkg::ByteW-1:0] b);
		int shift;
		if (cont_left == 2'd0) begin
			// Idle: the byte is a lead, an ASCII character, a stray continuation or garbage.
			if (b[7] == 1'b0) begin
				chars_due.push_back(make_char(u8d_pkg::CodeW'(b), u8d_pkg::ST_OK, 3'd1));
			end else if (b[7:6] == 2'b10) begin
				chars_due.push_back(make_char(u8d_pkg::CodeW'(b), u8d_pkg::ST_LONE, 3'd1));
			end else if (b[7:5] == 3'b110) begin
				cp_accum   = u8d_pkg::CodeW'(b[4:0]) << 6;
				cont_left  = 2'd1;
				seq_len    = 3'd2;
				seq_broken = 1'b0;
			end else if (b[7:4] == 4'b1110) begin
				cp_accum   = u8d_pkg::CodeW'(b[3:0]) << 12;
				cont_left  = 2'd2;
				seq_len    = 3'd3;
				seq_broken = 1'b0;
			end else if (b[7:3] == 5'b11110) begin
				cp_accum   = u8d_pkg::CodeW'(b[2:0]) << 18;
				cont_left  = 2'd3;
				seq_len    = 3'd4;
				seq_broken = 1'b0;
			end else begin
				chars_due.push_back(make_char('0, u8d_pkg::ST_INVALID, 3'd1));
			end
		end else begin
			// Inside a sequence every byte is consumed; once broken, payload stops growing.
			if (!seq_broken && b[7:6] == 2'b10) begin
				shift    = 6 * (int'(cont_left) - 1);
				cp_accum = cp_accum | (u8d_pkg::CodeW'(b[5:0]) << shift);
			end else begin
				seq_broken = 1'b1;
			end
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0) begin
				if (seq_broken)
					chars_due.push_back(make_char('0, u8d_pkg::ST_TRUNC, seq_len));
				else
					chars_due.push_back(make_char(cp_accum, u8d_pkg::ST_OK, seq_len));
				seq_len    = '0;
				cp_accum   = '0;
				seq_broken = 1'b0;
			end
		end
	endtask

	// Print one line per mismatch (up to a cap) and count it.
	task automatic report(input string msg);
		fails++;
		if (fails <= MaxPrints)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_char(input char_t got);
		char_t want;
		if (chars_due.size() == 0) begin
			report($sformatf("unexpected character cp=%h st=%0d cnt=%0d",
				got.code_point, got.status, got.byte_count));
		end else begin
			want = chars_due.pop_front();
			if (got.code_point !== want.code_point)
				report($sformatf("code_point %h, expected %h", got.code_point, want.code_point));
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.byte_count !== want.byte_count)
				report($sformatf("byte_count %0d, expected %0d", got.byte_count, want.byte_count));
			status_seen[want.status]++;
		end
		chars_checked++;
	endtask

	function automatic logic [7:0] cont_byte();
		logic [7:0] b;
		b      = 8'($urandom_range(255));
		b[7:6] = 2'b10;
		return b;
	endfunction

	function automatic logic [7:0] lead_byte(input int len);
		logic [7:0] b;
		b = 8'($urandom_range(255));
		case (len)
			2: begin
				b[7:5] = 3'b110;
			end
			3: begin
				b[7:4] = 4'b1110;
			end
			default: begin
				b[7:3] = 5'b11110;
			end
		endcase
		return b;
	endfunction

	// Queue about n bytes: mostly well-formed characters, plus broken sequences,
	// stray continuations, invalid leads and raw noise.
	task automatic fill_random(input int n);
		int added;
		int kind;
		int len;
		int pos;
		logic [7:0] b;
		added = 0;
		while (added < n) begin
			kind = $urandom_range(99);
			if (kind < 25) begin
				bytes_pending.push_back(8'($urandom_range(127)));
				added += 1;
			end else if (kind < 80) begin
				len = (kind < 45) ? 2 : (kind < 65) ? 3 : 4;
				bytes_pending.push_back(lead_byte(len));
				for (int i = 1; i < len; i++)
					bytes_pending.push_back(cont_byte());
				added += len;
			end else if (kind < 88) begin
				// Break the sequence at one random position; bytes around it are arbitrary.
				len = $urandom_range(4, 2);
				pos = $urandom_range(len - 1, 1);
				bytes_pending.push_back(lead_byte(len));
				for (int i = 1; i < len; i++) begin
					if (i == pos) begin
						b = 8'($urandom_range(255));
						if (b[7:6] == 2'b10)
							b[6] = 1'b1;
					end else if ($urandom_range(1) == 0) begin
						b = cont_byte();
					end else begin
						b = 8'($urandom_range(255));
					end
					bytes_pending.push_back(b);
				end
				added += len;
			end else if (kind < 92) begin
				bytes_pending.push_back(cont_byte());
				added += 1;
			end else if (kind < 95) begin
				bytes_pending.push_back(8'($urandom_range(255, 248)));
				added += 1;
			end else begin
				bytes_pending.push_back(8'($urandom_range(255)));
				added += 1;
			end
		end
	endtask

	// Hold the sequencing block until everything queued has gone in and every character has come out.
	task automatic drain();
		while (bytes_pending.size() != 0 || byte_chan.valid)
			@(posedge clk);
		while (chars_due.size() != 0)
			@(posedge clk);
	endtask

	// Byte driver: advance on the falling edge once the current byte has been taken.
	always @(negedge clk) begin
		if (arst_n && (!byte_chan.valid || byte_took)) begin
			if (bytes_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				byte_chan.valid   <= 1'b1;
				byte_chan.in_byte <= bytes_pending.pop_front();
			end else begin
				byte_chan.valid <= 1'b0;
			end
		end
	end

	// Character sink: random backpressure, plus one long hold in the full-rate phase
	// so the decoder fills up and drops its input ready.
	always @(negedge clk) begin
		if (!arst_n) begin
			char_chan.ready <= 1'b0;
		end else if (hold_left != 0) begin
			char_chan.ready <= 1'b0;
			hold_left       <= hold_left - 1;
		end else if (!hold_used && phase == PH_FULL_RATE && bytes_taken >= hold_mark) begin
			char_chan.ready <= 1'b0;
			hold_left       <= HoldCycles - 1;
			hold_used       <= 1'b1;
		end else begin
			char_chan.ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// Monitor: sample both channels on the rising edge; check characters, predict from bytes.
	always @(posedge clk) begin
		byte_took <= byte_chan.valid && byte_chan.ready;
		if (arst_n) begin
			if (char_chan.valid && char_chan.ready)
				check_char(make_char(char_chan.code_point, char_chan.status, char_chan.byte_count));
			if (byte_chan.valid && byte_chan.ready) begin
				decode_byte(byte_chan.in_byte);
				bytes_taken++;
			end
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_chan.valid && byte_chan.ready) || (char_chan.valid && char_chan.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("watchdog: no transaction for %0d cycles", IdleLimit);
				$display("utf8_byte_stream_decoder_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		byte_chan.valid   = 1'b0;
		byte_chan.in_byte = '0;
		char_chan.ready   = 1'b0;
		byte_took         = 1'b0;
		cont_left         = '0;
		seq_len           = '0;
		cp_accum          = '0;
		seq_broken        = 1'b0;
		bytes_taken       = 0;
		chars_checked     = 0;
		status_seen       = '{0, 0, 0, 0};
		fails             = 0;
		idle_cycles       = 0;
		hold_left         = 0;
		hold_used         = 1'b0;
		hold_mark         = 0;
		phase             = PH_SEND_FAST;
		send_gap_pct      = 9;
		recv_gap_pct      = 46;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ASCII limits, stray continuations, shortest and longest leads with
		// extreme payloads (overlong C0 80 too), invalid leads, a non-continuation inside
		// a 2-byte sequence, and a lead byte inside a 3-byte sequence.
		bytes_pending = '{8'h00, 8'h7F, 8'h80, 8'hBF,
			8'hC0, 8'h80, 8'hDF, 8'hBF,
			8'hE0, 8'h80, 8'h80,
			8'hF7, 8'hBF, 8'hBF, 8'hBF,
			8'hF8, 8'hFF,
			8'hC3, 8'h41,
			8'hE2, 8'hC3, 8'h80};
		fill_random(630);
		drain();

		phase        = PH_RECV_FAST;
		send_gap_pct = 46;
		recv_gap_pct = 9;
		fill_random(650);
		drain();

		phase        = PH_FULL_RATE;
		send_gap_pct = 0;
		recv_gap_pct = 0;
		hold_mark    = bytes_taken + 100;
		fill_random(650);
		drain();

		repeat (DrainCycles) @(posedge clk);

		$display("run: %0d bytes over three idle profiles, %0d characters checked",
			bytes_taken, chars_checked);
		$display("run: ok %0d, lone %0d, truncated %0d, invalid %0d; %0d-cycle output hold %s",
			status_seen[u8d_pkg::ST_OK], status_seen[u8d_pkg::ST_LONE],
			status_seen[u8d_pkg::ST_TRUNC], status_seen[u8d_pkg::ST_INVALID],
			HoldCycles, hold_used ? "done" : "missed");
		if (fails == 0) begin
			$display("utf8_byte_stream_decoder_tb: PASS");
		end else begin
			$display("%0d mismatches", fails);
			$display("utf8_byte_stream_decoder_tb: FAIL");
		end
		$finish;
	end

endmodule

[utf8_byte_stream_decoder.f]
+incdir+hw/rtl
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_byte_if.sv
hw/rtl/u8d_char_if.sv
hw/rtl/u8d_step.sv
hw/rtl/utf8_byte_stream_decoder.sv
tb/sv/utf8_byte_stream_decoder_tb.sv
